>>> design/cpl_pkg.sv
// Shared widths, register indexes and constants of the chassis power limiter.
`default_nettype none

package cpl_pkg;

    // Field widths of a request and of a result.
    localparam int CMD_W   = 16;   // one motor current command
    localparam int BUF_W   = 8;    // buffer energy and its threshold
    localparam int PWR_W   = 12;   // power in whole watts
    localparam int EST_W   = 19;   // power estimate in 1/256 W

    // Internal arithmetic widths.
    localparam int MAG_W   = 18;   // magnitude of the sum of four commands
    localparam int EST2_W  = 21;   // estimate in 1/512 W and permitted power in 1/512 W
    localparam int PROD_W  = CMD_W + PWR_W;     // |command| * permitted watts
    localparam int P2_SH   = 9;                 // watts to 1/512 W
    localparam int NUM_W   = PROD_W + P2_SH;    // dividend of the scaling
    localparam int QUO_W   = 16;                // scaled command magnitude
    localparam int LANES   = 4;

    localparam int S_TDATA_W = LANES * CMD_W + BUF_W;
    localparam int M_TDATA_W = LANES * CMD_W + EST_W + PWR_W + 1;

    localparam logic [EST_W-1:0] EST_MAX = '1;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PWR_W;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_POWER_WATTS  = 1'd1;

    localparam logic [BUF_W-1:0] BUFFER_THRESHOLD_RESET = 8'd5;
    localparam logic [PWR_W-1:0] MAX_POWER_WATTS_RESET  = 12'd80;

endpackage

`default_nettype wire

>>> design/chassis_power_limiter_unit.sv
// Top level of the chassis power limiter: handshake, estimate, permit and scaling pipeline.
`default_nettype none

// The block takes one request per clock cycle while its skid stage is empty and returns one
// result per request, in order. A result shows on m_tvalid once it has passed stages one to
// three, the divider stages and the output register. Each request carries four signed motor
// current commands and the referee buffer energy. Stage one registers the request, stage two
// forms the sum of the commands and the permitted power, stage three forms the power estimate
// (|sum| * 15 / 2 in 1/256 W), the limit decision and one 16 x 12 bit product per command,
// sixteen stages of a restoring divider per command then give the scaled magnitude one bit per
// stage, and a last stage applies the sign and picks the scaled or the original command. The
// divider pipeline sets the latency; the sustained rate is one request per cycle while m_tready
// stays high. An output register with a one-entry skid stage behind it separates the two sides,
// so s_tready is a register and a new request is taken while a finished result waits, until the
// skid stage fills. The two configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata and should change only while no request is in flight.
module chassis_power_limiter_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // command_a, command_b, command_c, command_d, buffer_energy (from bit 0 up)
    input  wire logic [cpl_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // limited_a, limited_b, limited_c, limited_d, power_estimate, permitted_power,
    // was_limited (from bit 0 up)
    output logic      [cpl_pkg::M_TDATA_W-1:0]     m_tdata,

    input  wire logic                              cfg_we,
    input  wire logic [cpl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [cpl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cpl_pkg::*;

    // Fields that ride alongside the divider.
    typedef struct packed {
        logic [LANES-1:0][CMD_W-1:0] cmd;
        logic [EST_W-1:0]            est;
        logic [PWR_W-1:0]            permit;
        logic                        limit;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [BUF_W-1:0] threshold_reg;
    logic [PWR_W-1:0] max_power_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= BUFFER_THRESHOLD_RESET;
            max_power_reg <= MAX_POWER_WATTS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BUFFER_THRESHOLD: threshold_reg <= cfg_wdata[BUF_W-1:0];
                REG_MAX_POWER_WATTS:  max_power_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable. The whole pipeline advances while the skid stage is
    // empty; the output register or the skid stage always has room then.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: register the request.
    // ------------------------------------------------------------------
    logic                        p1_valid_reg;
    logic [LANES-1:0][CMD_W-1:0] p1_cmd_reg;
    logic [BUF_W-1:0]            p1_buf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_cmd_reg <= s_tdata[LANES*CMD_W-1:0];
            p1_buf_reg <= s_tdata[S_TDATA_W-1:LANES*CMD_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude of the command sum and the permitted power.
    // Below the threshold the fixed maximum applies, otherwise ten watts
    // per joule of buffer above the threshold.
    // ------------------------------------------------------------------
    logic signed [MAG_W-1:0] sum;
    logic        [MAG_W-1:0] mag;
    logic        [BUF_W-1:0] excess;
    logic        [PWR_W-1:0] permit;

    always_comb begin
        sum = MAG_W'(signed'(p1_cmd_reg[0])) + MAG_W'(signed'(p1_cmd_reg[1]))
            + MAG_W'(signed'(p1_cmd_reg[2])) + MAG_W'(signed'(p1_cmd_reg[3]));
        mag = sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        excess = p1_buf_reg - threshold_reg;
        if (p1_buf_reg < threshold_reg) begin
            permit = max_power_reg;
        end else begin
            permit = PWR_W'({excess, 3'b000}) + PWR_W'({excess, 1'b0});
        end
    end

    logic                        p2_valid_reg;
    logic [LANES-1:0][CMD_W-1:0] p2_cmd_reg;
    logic [MAG_W-1:0]            p2_mag_reg;
    logic [PWR_W-1:0]            p2_permit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_cmd_reg    <= p1_cmd_reg;
            p2_mag_reg    <= mag;
            p2_permit_reg <= permit;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: estimate, limit decision and the per-lane dividends.
    // The estimate in 1/512 W is |sum| * 15; the scaling ratio is
    // permit * 512 / (|sum| * 15), applied to each command magnitude.
    // ------------------------------------------------------------------
    logic [EST2_W-1:0]           est2;
    logic [EST2_W-2:0]           est_full;
    logic [EST_W-1:0]            est;
    logic [EST2_W-1:0]           permit2;
    logic                        limit;
    logic [LANES-1:0][CMD_W-1:0] cmd_abs;
    logic [LANES-1:0][PROD_W-1:0] prod;

    always_comb begin
        est2     = EST2_W'({p2_mag_reg, 4'b0000}) - EST2_W'(p2_mag_reg);
        est_full = est2[EST2_W-1:1];
        est      = (est_full > (EST2_W-1)'(EST_MAX)) ? EST_MAX : est_full[EST_W-1:0];
        permit2  = EST2_W'({p2_permit_reg, {P2_SH{1'b0}}});
        limit    = (p2_mag_reg != '0) && (est2 >= permit2);
        for (int i = 0; i < LANES; i++) begin
            cmd_abs[i] = p2_cmd_reg[i][CMD_W-1] ? CMD_W'(-p2_cmd_reg[i]) : p2_cmd_reg[i];
            prod[i]    = PROD_W'(cmd_abs[i]) * PROD_W'(p2_permit_reg);
        end
    end

    logic                         p3_valid_reg;
    side_t                        p3_side_reg;
    logic [EST2_W-1:0]            p3_den_reg;
    logic [LANES-1:0][PROD_W-1:0] p3_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg.cmd    <= p2_cmd_reg;
            p3_side_reg.est    <= est;
            p3_side_reg.permit <= p2_permit_reg;
            p3_side_reg.limit  <= limit;
            p3_den_reg         <= est2;
            p3_prod_reg        <= prod;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: one divider per command lane, with the side fields
    // and valid bits delayed to match.
    // ------------------------------------------------------------------
    logic [LANES-1:0][QUO_W-1:0] quot;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            cpl_divider u_div (
                .aclk  (aclk),
                .en    (en),
                .numer ({p3_prod_reg[g], {P2_SH{1'b0}}}),
                .denom (p3_den_reg),
                .quot  (quot[g])
            );
        end
    endgenerate

    logic [QUO_W-1:0] dv_valid_reg;
    side_t            dv_side_reg [0:QUO_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg <= '0;
        end else if (en) begin
            dv_valid_reg <= {dv_valid_reg[QUO_W-2:0], p3_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= p3_side_reg;
            for (int i = 1; i < QUO_W; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: restore the sign of each scaled command, truncating
    // toward zero, or pass the original command when no limit applies.
    // ------------------------------------------------------------------
    side_t                        last_side;
    logic                         last_valid;
    logic [LANES-1:0][CMD_W-1:0]  limited;
    logic [M_TDATA_W-1:0]         result;

    assign last_side  = dv_side_reg[QUO_W-1];
    assign last_valid = dv_valid_reg[QUO_W-1];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (last_side.limit) begin
                limited[i] = last_side.cmd[i][CMD_W-1] ? CMD_W'(-quot[i]) : CMD_W'(quot[i]);
            end else begin
                limited[i] = last_side.cmd[i];
            end
        end
        result = {last_side.limit, last_side.permit, last_side.est, limited};
    end

    // ------------------------------------------------------------------
    // Output register and skid stage. A result that arrives while the
    // output register is held goes to the skid stage, which stops the
    // pipeline until the output register takes it over.
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (m_tready) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (last_valid) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (last_valid) begin
            if (out_free) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> design/cpl_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for one command lane.
`default_nettype none

module cpl_divider (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [cpl_pkg::NUM_W-1:0]   numer,
    input  wire logic [cpl_pkg::EST2_W-1:0]  denom,
    output logic      [cpl_pkg::QUO_W-1:0]   quot
);
    import cpl_pkg::*;

    // The caller guarantees numer < denom * 2**QUO_W whenever the quotient is used,
    // so the upper part of the dividend already starts below the divisor.
    logic [EST2_W-1:0] rem_reg [1:QUO_W];
    logic [EST2_W-1:0] den_reg [1:QUO_W];
    logic [QUO_W-1:0]  low_reg [1:QUO_W];
    logic [QUO_W-1:0]  quo_reg [1:QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic [EST2_W-1:0] cur_rem;
            logic [EST2_W-1:0] cur_den;
            logic [QUO_W-1:0]  cur_low;
            logic [QUO_W-1:0]  cur_quo;
            logic [EST2_W:0]   trial;
            logic              take;
            logic [EST2_W:0]   diff;
            logic [QUO_W-1:0]  quo_next;

            if (k == 0) begin : g_first
                assign cur_rem = numer[NUM_W-1:QUO_W];
                assign cur_den = denom;
                assign cur_low = numer[QUO_W-1:0];
                assign cur_quo = '0;
            end else begin : g_rest
                assign cur_rem = rem_reg[k];
                assign cur_den = den_reg[k];
                assign cur_low = low_reg[k];
                assign cur_quo = quo_reg[k];
            end

            assign trial = {cur_rem, cur_low[QUO_W-1-k]};
            assign take  = (trial >= {1'b0, cur_den});
            assign diff  = trial - {1'b0, cur_den};

            always_comb begin
                quo_next = cur_quo;
                quo_next[QUO_W-1-k] = take;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= take ? diff[EST2_W-1:0] : trial[EST2_W-1:0];
                    den_reg[k+1] <= cur_den;
                    low_reg[k+1] <= cur_low;
                    quo_reg[k+1] <= quo_next;
                end
            end
        end
    endgenerate

    assign quot = quo_reg[QUO_W];

endmodule

`default_nettype wire

>>> tb/tb_chassis_power_limiter_unit.sv
// Self-checking testbench for the chassis power limiter: random and directed requests.
module tb_chassis_power_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cpl_pkg::*;

    // Runaway guard.
    localparam int CYCLE_LIMIT = 200000;
    // Settle time after each drain, with margin over the depth of the result pipeline.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_REQUESTS = 500;

    // A request as it travels on s_tdata: commands from bit 0 up, buffer energy on top.
    typedef struct packed {
        logic [BUF_W-1:0]                buffer_energy;
        logic [LANES-1:0][CMD_W-1:0]     commands;
    } power_request_t;

    // A result as it travels on m_tdata: limited commands from bit 0 up, then the
    // estimate, the permitted power and the limit flag in the top bit.
    typedef struct packed {
        logic                            was_limited;
        logic [PWR_W-1:0]                permitted_power;
        logic [EST_W-1:0]                power_estimate;
        logic [LANES-1:0][CMD_W-1:0]     limited;
    } limiter_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    // The testbench's own copy of the two configuration registers.
    logic [BUF_W-1:0]        threshold_setting = BUFFER_THRESHOLD_RESET;
    logic [PWR_W-1:0]        max_power_setting = MAX_POWER_WATTS_RESET;

    power_request_t          pending_requests[$];
    limiter_result_t         expected_results[$];

    int                      sender_idle_pct = 0;
    int                      receiver_stall_pct = 0;
    int                      requests_queued = 0;
    int                      requests_accepted = 0;
    int                      results_seen = 0;
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    bit                      request_taken = 1'b0;

    chassis_power_limiter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Computes what the limiter should return for one request under the current
    // register settings. The arithmetic is done at 64 bits so nothing overflows:
    // the estimate in 1/512 W is |sum| * 15, the permitted power in 1/512 W is
    // watts * 512, and each command is scaled by their ratio, truncated toward zero.
    function automatic limiter_result_t predict_limited(input power_request_t req);
        longint          cmd[LANES];
        longint          sum;
        longint          mag;
        longint          est_half_lsb;
        longint          estimate;
        longint          permit;
        longint          permit_half_lsb;
        longint          scaled;
        logic            limit;
        limiter_result_t res;
        sum = 0;
        for (int i = 0; i < LANES; i++) begin
            cmd[i] = longint'($signed(req.commands[i]));
            sum += cmd[i];
        end
        mag = (sum < 0) ? -sum : sum;
        est_half_lsb = mag * 15;
        estimate = est_half_lsb / 2;
        // The estimate only overflows its field for commands outside the nominal range.
        if (estimate > longint'(EST_MAX)) begin
            estimate = longint'(EST_MAX);
        end
        if (req.buffer_energy < threshold_setting) begin
            permit = longint'(max_power_setting);
        end else begin
            permit = (longint'(req.buffer_energy) - longint'(threshold_setting)) * 10;
        end
        permit_half_lsb = permit * 512;
        // A zero sum never limits, even with nothing permitted; a tie does limit.
        limit = (mag != 0) && (est_half_lsb >= permit_half_lsb);
        for (int i = 0; i < LANES; i++) begin
            scaled = limit ? (cmd[i] * permit_half_lsb) / est_half_lsb : cmd[i];
            res.limited[i] = scaled[CMD_W-1:0];
        end
        res.power_estimate = estimate[EST_W-1:0];
        res.permitted_power = permit[PWR_W-1:0];
        res.was_limited = limit;
        return res;
    endfunction

    function automatic power_request_t make_request(input int a, input int b, input int c,
                                                     input int d, input int energy);
        power_request_t req;
        req.commands[0] = CMD_W'(a);
        req.commands[1] = CMD_W'(b);
        req.commands[2] = CMD_W'(c);
        req.commands[3] = CMD_W'(d);
        req.buffer_energy = BUF_W'(energy);
        return req;
    endfunction

    // Random requests. Command sets are drawn from several shapes so the estimate
    // lands both well above and well below the permitted power; the buffer energy
    // is often placed close to the threshold, where the permit rule switches over.
    function automatic power_request_t random_request();
        power_request_t req;
        int             shape;
        int             first;
        int             second;
        int             energy;
        shape = $urandom_range(99);
        for (int i = 0; i < LANES; i++) begin
            if (shape < 30) begin
                req.commands[i] = CMD_W'($urandom_range(32768) - 16384);
            end else if (shape < 55) begin
                req.commands[i] = CMD_W'($urandom_range(4000) - 2000);
            end else if (shape < 65) begin
                req.commands[i] = CMD_W'($urandom);
            end else if (shape < 75) begin
                req.commands[i] = '0;
            end else if (shape < 85) begin
                req.commands[i] = CMD_W'($urandom_range(16384));
            end else begin
                req.commands[i] = CMD_W'($urandom_range(128) - 64);
            end
        end
        // Part of the sets cancel out exactly, which gives a zero estimate.
        if (shape >= 65 && shape < 75) begin
            first = $urandom_range(32768) - 16384;
            second = $urandom_range(32768) - 16384;
            req.commands[0] = CMD_W'(first);
            req.commands[1] = CMD_W'(-first);
            req.commands[2] = CMD_W'(second);
            req.commands[3] = CMD_W'(-second);
        end
        // Commands of one sign with a negative draw half the time.
        if (shape >= 85 - 10 && shape < 85 && $urandom_range(1) == 1) begin
            for (int i = 0; i < LANES; i++) begin
                req.commands[i] = -req.commands[i];
            end
        end
        if ($urandom_range(99) < 60) begin
            energy = $urandom_range(255);
        end else begin
            energy = int'(threshold_setting) + $urandom_range(20) - 5;
            if (energy < 0) energy = 0;
            if (energy > 255) energy = 255;
        end
        req.buffer_energy = BUF_W'(energy);
        return req;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Registers are written at a falling edge and taken at the next rising edge.
    // The local copy changes at once, which is safe because the block is idle.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_BUFFER_THRESHOLD) begin
            threshold_setting = value[BUF_W-1:0];
        end else begin
            max_power_setting = value;
        end
    endtask

    task automatic queue_request(input power_request_t req);
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Returns once every queued request has been taken and answered, plus the
    // pipeline depth, so that no request is in flight afterwards.
    task automatic drain_block();
        while (requests_accepted != requests_queued || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Request driver. A new request is presented at the falling edge once the
    // previous one was taken (or none was shown); with the sender idling, a
    // random share of those slots stays empty. The receiver ready is redrawn
    // each cycle according to the stall share of the phase.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || request_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tdata <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
        request_taken = 1'b0;
    end

    // Monitor. Accepted requests are turned into expectations on the spot, and
    // every result is checked field by field against the oldest expectation.
    always @(posedge aclk) begin
        limiter_result_t got;
        limiter_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_limited(power_request_t'(s_tdata)));
                requests_accepted++;
                request_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = limiter_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending: 0x%0h",
                                              results_seen, m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    for (int i = 0; i < LANES; i++) begin
                        if (got.limited[i] !== want.limited[i]) begin
                            report_mismatch($sformatf("result %0d limited lane %0d is %0d, want %0d",
                                results_seen, i, $signed(got.limited[i]),
                                $signed(want.limited[i])));
                        end
                    end
                    if (got.power_estimate !== want.power_estimate) begin
                        report_mismatch($sformatf("result %0d power_estimate is %0d, want %0d",
                            results_seen, got.power_estimate, want.power_estimate));
                    end
                    if (got.permitted_power !== want.permitted_power) begin
                        report_mismatch($sformatf("result %0d permitted_power is %0d, want %0d",
                            results_seen, got.permitted_power, want.permitted_power));
                    end
                    if (got.was_limited !== want.was_limited) begin
                        report_mismatch($sformatf("result %0d was_limited is %0b, want %0b",
                            results_seen, got.was_limited, want.was_limited));
                    end
                end
                results_seen++;
            end
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset settings (threshold 5, 80 W).
        // Zero commands with an empty buffer, and the nominal extremes.
        queue_request(make_request(0, 0, 0, 0, 0));
        queue_request(make_request(16384, 16384, 16384, 16384, 255));
        queue_request(make_request(-16384, -16384, -16384, -16384, 0));
        // Commands beyond the nominal range: the estimate saturates.
        queue_request(make_request(32767, 32767, 32767, 32767, 255));
        // Full negative commands with nothing permitted scale to zero.
        queue_request(make_request(-32768, -32768, -32768, -32768, 5));
        // A zero sum passes unchanged even with nothing permitted.
        queue_request(make_request(100, -100, 50, -50, 5));
        // Estimate exactly equal to the 30 W permit: limited with a ratio of one.
        queue_request(make_request(256, 256, 256, 256, 8));
        // One step below that tie: not limited.
        queue_request(make_request(256, 256, 256, 255, 8));
        // Smallest nonzero estimate against a zero permit.
        queue_request(make_request(1, 0, 0, 0, 5));
        // Mixed signs, truncation toward zero for negative commands.
        queue_request(make_request(16384, -16384, 16384, -1, 3));
        queue_request(make_request(1000, 2000, -300, 4000, 0));
        queue_request(make_request(-1000, 3, 7, -2001, 6));
        // Buffer just below, at and just above the threshold.
        queue_request(make_request(3000, 3000, 3000, 3000, 4));
        queue_request(make_request(3000, 3000, 3000, 3000, 5));
        queue_request(make_request(3000, 3000, 3000, 3000, 6));
        // Alternating bit patterns in every field, then all bits set.
        queue_request(make_request(21845, -21846, 21845, -21846, 170));
        queue_request(make_request(-21846, 21845, -21846, 21845, 85));
        queue_request(make_request(-1, -1, -1, -1, 255));
        drain_block();

        // Phase one: both registers at zero, no idling on either side.
        write_register(REG_BUFFER_THRESHOLD, '0);
        write_register(REG_MAX_POWER_WATTS, '0);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(posedge aclk);
        repeat (PHASE_REQUESTS) queue_request(random_request());
        drain_block();

        // Phase two: top of the nominal ranges, a mostly idle sender.
        write_register(REG_BUFFER_THRESHOLD, CFG_DATA_W'(255));
        write_register(REG_MAX_POWER_WATTS, CFG_DATA_W'(2550));
        sender_idle_pct = 77;
        receiver_stall_pct = 0;
        @(posedge aclk);
        repeat (PHASE_REQUESTS) queue_request(random_request());
        drain_block();

        // Phase three: all write data bits set for the power limit, and stray
        // upper bits on the threshold write; a mostly stalled receiver.
        write_register(REG_BUFFER_THRESHOLD, CFG_DATA_W'(12'hF3C));
        write_register(REG_MAX_POWER_WATTS, '1);
        sender_idle_pct = 0;
        receiver_stall_pct = 77;
        @(posedge aclk);
        repeat (PHASE_REQUESTS) queue_request(random_request());
        drain_block();

        // Phase four: random settings, idling and stalling together.
        write_register(REG_BUFFER_THRESHOLD, CFG_DATA_W'($urandom_range(255)));
        write_register(REG_MAX_POWER_WATTS, CFG_DATA_W'($urandom_range(2550)));
        sender_idle_pct = 36;
        receiver_stall_pct = 36;
        @(posedge aclk);
        repeat (PHASE_REQUESTS) queue_request(random_request());
        drain_block();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
